[rtl/sprs_pkg.sv]
// Shared constants, types and state encoding for the slotted page record store.
// No dependencies; sprs_ctrl, the top level and the testbench import this package.
`default_nettype none

package sprs_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int PAGE_AW      = 12;
	localparam int PTR_W        = 13;
	localparam int LEN_W        = 12;
	localparam int HEADER_BYTES = 24;
	localparam int SLOT_BYTES   = 6;
	localparam int MAX_SLOTS    = 1024;
	localparam int SLOT_AW      = 10;
	localparam int CNT_W        = 11;
	localparam int MAX_SPECIAL  = PAGE_BYTES - HEADER_BYTES;

	localparam logic [2:0] CMD_FORMAT    = 3'd0;
	localparam logic [2:0] CMD_INSERT    = 3'd1;
	localparam logic [2:0] CMD_READ      = 3'd2;
	localparam logic [2:0] CMD_OVERWRITE = 3'd3;
	localparam logic [2:0] CMD_DELETE    = 3'd4;

	localparam logic [2:0] STS_OK       = 3'd0;
	localparam logic [2:0] STS_ZERO_LEN = 3'd1;
	localparam logic [2:0] STS_NO_SPACE = 3'd2;
	localparam logic [2:0] STS_NO_SLOT  = 3'd3;
	localparam logic [2:0] STS_NOT_OCC  = 3'd4;
	localparam logic [2:0] STS_TOO_LONG = 3'd5;
	localparam logic [2:0] STS_RANGE    = 3'd6;

	localparam logic [1:0] SL_EMPTY    = 2'd0;
	localparam logic [1:0] SL_OCCUPIED = 2'd1;
	localparam logic [1:0] SL_DELETED  = 2'd2;

	typedef struct packed {
		logic [PTR_W-1:0] off;
		logic [PTR_W-1:0] len;
		logic [1:0]       st;
	} slot_entry_t;

	typedef struct packed {
		logic               we;
		logic [PAGE_AW-1:0] addr;
		logic [7:0]         wdata;
	} byte_req_t;

	typedef struct packed {
		logic               we;
		logic [SLOT_AW-1:0] addr;
		slot_entry_t        wdata;
	} slot_req_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_SCAN_RD, ST_SCAN_EV, ST_FIT,
		ST_C1_RD, ST_C1_EV, ST_C1_CP, ST_C2,
		ST_C3_RD, ST_C3_EV, ST_C3_CP, ST_C3_END,
		ST_ALLOC, ST_OW_EV, ST_STREAM, ST_ZTAIL, ST_FMT,
		ST_ACC_EV, ST_RD_WAIT, ST_FINISH
	} state_t;

endpackage

`default_nettype wire

[rtl/sprs_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module sprs_ram #(
	parameter int W  = 8,
	parameter int AW = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [W-1:0]  wdata,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

[rtl/sprs_ctrl.sv]
// Sequencer for the slotted page: command decode, slot walks, compaction,
// byte streaming and result register. Depends on sprs_pkg; drives three RAMs.
`default_nettype none

module sprs_ctrl import sprs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_wdata,
	output byte_req_t        page_req,
	input  wire logic [7:0]  page_rdata,
	output byte_req_t        scr_req,
	input  wire logic [7:0]  scr_rdata,
	output slot_req_t        slot_req,
	input  slot_entry_t      slot_rdata
);

	state_t state_q, state_d;

	logic [11:0]      special_size_q;
	logic [PTR_W-1:0] lower_q, upper_q, special_q;
	logic [CNT_W-1:0] total_q;
	logic [PTR_W-1:0] bc_q;
	logic [SLOT_AW-1:0] pend_q;
	logic             failed_q;
	logic [PTR_W-1:0] cur_off_q, cur_len_q;

	logic [2:0]         cmd_q;
	logic [SLOT_AW-1:0] slot_q;
	logic [LEN_W-1:0]   bidx_q, len_q;
	logic [7:0]         data_q;
	logic               last_q;

	logic [2:0]         res_status_q;
	logic [SLOT_AW-1:0] res_sout_q;
	logic [7:0]         res_dout_q;
	logic [LEN_W-1:0]   res_lout_q;

	logic [CNT_W-1:0]   idx_q;
	logic               found_q;
	logic [SLOT_AW-1:0] free_idx_q;
	logic [PTR_W:0]     reclaim_q;
	logic [PTR_W-1:0]   n_q, k_q, z_q, top_q, cp_off_q, cp_len_q, dst_q;
	logic               rd_oob_q;

	logic               cp1_v_s1, cp1_oob_s1;
	logic [PTR_W-1:0]   cp1_dst_s1;
	logic               cp3_v_s1, cp3_zero_s1;
	logic [PTR_W-1:0]   cp3_dst_s1;

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;

	// input fields
	logic [2:0]         in_cmd;
	logic [SLOT_AW-1:0] in_slot;
	logic [LEN_W-1:0]   in_bidx, in_len;
	logic [7:0]         in_data;
	logic               in_strm, fly, accept;

	// byte step
	logic [2:0]       b_cmd;
	logic [LEN_W-1:0] b_len;
	logic [7:0]       b_data;
	logic             b_last, b_wr;
	logic [PTR_W-1:0] b_addr, tail_from;

	logic [PTR_W-1:0] free_sp, req, c3_top, alloc_up, cp_addr, rd_addr, za_addr;
	logic [SLOT_AW-1:0] alloc_idx;
	logic             fit_ok, reclaim_ok, refit_ok, idx_end, slot_bad;

	assign in_cmd  = s_tdata[2:0];
	assign in_slot = s_tdata[12:3];
	assign in_bidx = s_tdata[24:13];
	assign in_len  = s_tdata[36:25];
	assign in_data = s_tdata[44:37];
	assign in_strm = (in_cmd == CMD_INSERT) || (in_cmd == CMD_OVERWRITE);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	// continuing byte of an open stream: handled without leaving idle
	assign fly      = accept && in_strm && (bc_q != '0);

	assign b_cmd  = (state_q == ST_STREAM) ? cmd_q  : in_cmd;
	assign b_len  = (state_q == ST_STREAM) ? len_q  : in_len;
	assign b_data = (state_q == ST_STREAM) ? data_q : in_data;
	assign b_last = (state_q == ST_STREAM) ? last_q : s_tlast;
	assign b_addr = cur_off_q + bc_q;
	assign b_wr   = (fly || state_q == ST_STREAM) && !failed_q &&
		(bc_q < cur_len_q) && (bc_q < {1'b0, b_len});
	assign tail_from = ({1'b0, b_len} < cur_len_q) ? {1'b0, b_len} : cur_len_q;

	assign free_sp  = upper_q - lower_q;
	assign req      = {1'b0, len_q} + (found_q ? '0 : PTR_W'(SLOT_BYTES));
	assign fit_ok   = free_sp >= req;
	assign reclaim_ok = ({1'b0, free_sp} + reclaim_q) >= {1'b0, req};
	assign refit_ok = (top_q - lower_q) >= req;
	assign c3_top   = (top_q >= slot_rdata.len) ? top_q - slot_rdata.len : '0;
	assign alloc_idx = found_q ? free_idx_q : total_q[SLOT_AW-1:0];
	assign alloc_up = upper_q - {1'b0, len_q};
	assign cp_addr  = cp_off_q + k_q;
	assign rd_addr  = slot_rdata.off + {1'b0, bidx_q};
	assign za_addr  = cur_off_q + z_q;
	assign idx_end  = (idx_q + CNT_W'(1)) == total_q;
	assign slot_bad = {1'b0, slot_q} >= total_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_cmd <= CMD_DELETE) begin
					if (fly) begin
						if (s_tlast) begin
							state_d = (!failed_q && in_cmd == CMD_OVERWRITE) ? ST_ZTAIL
								: ST_FINISH;
						end
					end else begin
						state_d = ST_DISP;
					end
				end
			end
			ST_DISP: begin
				case (cmd_q)
					CMD_FORMAT:    state_d = (special_size_q > 12'(MAX_SPECIAL)) ? ST_FINISH
						: ST_FMT;
					CMD_INSERT: begin
						if (len_q == '0) state_d = ST_STREAM;
						else if (total_q == '0) state_d = ST_FIT;
						else state_d = ST_SCAN_RD;
					end
					CMD_OVERWRITE: state_d = slot_bad ? ST_STREAM : ST_OW_EV;
					default:       state_d = slot_bad ? ST_FINISH : ST_ACC_EV;
				endcase
			end
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: state_d = idx_end ? ST_FIT : ST_SCAN_RD;
			ST_FIT: begin
				if (!found_q && total_q == CNT_W'(MAX_SLOTS)) state_d = ST_STREAM;
				else if (fit_ok) state_d = ST_ALLOC;
				else if (!reclaim_ok) state_d = ST_STREAM;
				else if (total_q == '0) state_d = ST_C2;
				else state_d = ST_C1_RD;
			end
			ST_C1_RD: state_d = ST_C1_EV;
			ST_C1_EV: begin
				if (slot_rdata.st == SL_OCCUPIED && slot_rdata.len != '0) state_d = ST_C1_CP;
				else state_d = idx_end ? ST_C2 : ST_C1_RD;
			end
			ST_C1_CP: begin
				if (k_q + PTR_W'(1) == cp_len_q) begin
					state_d = (idx_q == total_q) ? ST_C2 : ST_C1_RD;
				end
			end
			ST_C2: begin
				if (z_q >= special_q) state_d = (total_q == '0) ? ST_C3_END : ST_C3_RD;
			end
			ST_C3_RD: state_d = ST_C3_EV;
			ST_C3_EV: begin
				if (slot_rdata.st == SL_OCCUPIED && slot_rdata.len != '0) state_d = ST_C3_CP;
				else state_d = idx_end ? ST_C3_END : ST_C3_RD;
			end
			ST_C3_CP: begin
				if (k_q + PTR_W'(1) == cp_len_q) begin
					state_d = (idx_q == total_q) ? ST_C3_END : ST_C3_RD;
				end
			end
			ST_C3_END: state_d = refit_ok ? ST_ALLOC : ST_STREAM;
			ST_ALLOC:  state_d = ST_STREAM;
			ST_OW_EV:  state_d = ST_STREAM;
			ST_STREAM: begin
				if (last_q) begin
					state_d = (!failed_q && cmd_q == CMD_OVERWRITE) ? ST_ZTAIL : ST_FINISH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ZTAIL: if (z_q >= cur_len_q) state_d = ST_FINISH;
			ST_FMT:   if (z_q == PTR_W'(PAGE_BYTES - 1)) state_d = ST_FINISH;
			ST_ACC_EV: begin
				if (slot_rdata.st == SL_OCCUPIED && cmd_q == CMD_READ &&
					{1'b0, bidx_q} < slot_rdata.len) begin
					state_d = ST_RD_WAIT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_RD_WAIT: state_d = ST_FINISH;
			ST_FINISH:  if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		page_req = '0;
		scr_req  = '0;
		slot_req = '0;
		case (state_q)
			ST_IDLE, ST_STREAM: begin
				page_req.we    = b_wr && !b_addr[PTR_W-1];
				page_req.addr  = b_addr[PAGE_AW-1:0];
				page_req.wdata = b_data;
			end
			ST_DISP: slot_req.addr = slot_q;
			ST_SCAN_RD, ST_C1_RD, ST_C3_RD: slot_req.addr = idx_q[SLOT_AW-1:0];
			ST_C1_EV: begin
				slot_req.addr  = idx_q[SLOT_AW-1:0];
				slot_req.we    = slot_rdata.st != SL_OCCUPIED;
				slot_req.wdata = '{off: '0, len: '0, st: slot_rdata.st};
			end
			ST_C1_CP: page_req.addr = cp_addr[PAGE_AW-1:0];
			ST_C2: begin
				page_req.we   = z_q < special_q;
				page_req.addr = z_q[PAGE_AW-1:0];
			end
			ST_C3_EV: begin
				slot_req.addr  = idx_q[SLOT_AW-1:0];
				slot_req.we    = slot_rdata.st == SL_OCCUPIED;
				slot_req.wdata = '{off: c3_top, len: slot_rdata.len, st: slot_rdata.st};
			end
			ST_C3_CP: scr_req.addr = n_q[PAGE_AW-1:0];
			ST_ALLOC: begin
				slot_req.we    = 1'b1;
				slot_req.addr  = alloc_idx;
				slot_req.wdata = '{off: alloc_up, len: {1'b0, len_q}, st: SL_OCCUPIED};
			end
			ST_ZTAIL: begin
				page_req.we   = (z_q < cur_len_q) && !za_addr[PTR_W-1];
				page_req.addr = za_addr[PAGE_AW-1:0];
			end
			ST_FMT: begin
				page_req.we   = 1'b1;
				page_req.addr = z_q[PAGE_AW-1:0];
			end
			ST_ACC_EV: begin
				page_req.addr  = rd_addr[PAGE_AW-1:0];
				slot_req.addr  = slot_q;
				slot_req.we    = slot_rdata.st == SL_OCCUPIED && cmd_q == CMD_DELETE;
				slot_req.wdata = '{off: slot_rdata.off, len: slot_rdata.len, st: SL_DELETED};
			end
			default: ;
		endcase
		// each copy write is issued in the cycle after its read
		if (cp1_v_s1) begin
			scr_req.we    = !cp1_dst_s1[PTR_W-1];
			scr_req.addr  = cp1_dst_s1[PAGE_AW-1:0];
			scr_req.wdata = cp1_oob_s1 ? 8'h00 : page_rdata;
		end
		if (cp3_v_s1) begin
			page_req.we    = !cp3_dst_s1[PTR_W-1];
			page_req.addr  = cp3_dst_s1[PAGE_AW-1:0];
			page_req.wdata = cp3_zero_s1 ? 8'h00 : scr_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			special_size_q <= '0;
			lower_q        <= PTR_W'(HEADER_BYTES);
			upper_q        <= PTR_W'(PAGE_BYTES);
			special_q      <= PTR_W'(PAGE_BYTES);
			total_q        <= '0;
			bc_q           <= '0;
			pend_q         <= '0;
			failed_q       <= 1'b0;
			cp1_v_s1       <= 1'b0;
			cp3_v_s1       <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			cp1_v_s1 <= state_q == ST_C1_CP;
			cp3_v_s1 <= state_q == ST_C3_CP;
			if (cfg_we) begin
				special_size_q <= cfg_wdata;
			end
			if (state_q == ST_FINISH && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (fly || state_q == ST_STREAM) begin
				if (!b_last) begin
					if (bc_q != '1) bc_q <= bc_q + PTR_W'(1);
				end else begin
					bc_q     <= '0;
					failed_q <= 1'b0;
				end
			end

			case (state_q)
				ST_DISP: begin
					case (cmd_q)
						CMD_FORMAT: begin
							bc_q     <= '0;
							failed_q <= 1'b0;
							if (special_size_q <= 12'(MAX_SPECIAL)) begin
								lower_q   <= PTR_W'(HEADER_BYTES);
								special_q <= PTR_W'(PAGE_BYTES) - {1'b0, special_size_q};
								upper_q   <= PTR_W'(PAGE_BYTES) - {1'b0, special_size_q};
								total_q   <= '0;
							end
						end
						CMD_INSERT: begin
							if (len_q == '0) begin
								failed_q <= 1'b1;
								pend_q   <= SLOT_AW'(STS_ZERO_LEN);
							end
						end
						CMD_OVERWRITE: begin
							if (slot_bad) begin
								failed_q <= 1'b1;
								pend_q   <= SLOT_AW'(STS_NO_SLOT);
							end
						end
						default: begin
							bc_q     <= '0;
							failed_q <= 1'b0;
						end
					endcase
				end
				ST_FIT: begin
					if (!found_q && total_q == CNT_W'(MAX_SLOTS)) begin
						failed_q <= 1'b1;
						pend_q   <= SLOT_AW'(STS_NO_SLOT);
					end else if (!fit_ok && !reclaim_ok) begin
						failed_q <= 1'b1;
						pend_q   <= SLOT_AW'(STS_NO_SPACE);
					end
				end
				ST_C3_END: begin
					upper_q <= top_q;
					if (!refit_ok) begin
						failed_q <= 1'b1;
						pend_q   <= SLOT_AW'(STS_NO_SPACE);
					end
				end
				ST_ALLOC: begin
					if (!found_q) begin
						total_q <= total_q + CNT_W'(1);
						lower_q <= lower_q + PTR_W'(SLOT_BYTES);
					end
					upper_q  <= alloc_up;
					pend_q   <= alloc_idx;
					failed_q <= 1'b0;
				end
				ST_OW_EV: begin
					if (slot_rdata.st != SL_OCCUPIED) begin
						failed_q <= 1'b1;
						pend_q   <= SLOT_AW'(STS_NOT_OCC);
					end else if ({1'b0, len_q} > slot_rdata.len) begin
						failed_q <= 1'b1;
						pend_q   <= SLOT_AW'(STS_TOO_LONG);
					end else begin
						failed_q <= 1'b0;
						pend_q   <= slot_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		cp1_oob_s1  <= cp_addr[PTR_W-1];
		cp1_dst_s1  <= n_q;
		cp3_zero_s1 <= n_q[PTR_W-1];
		cp3_dst_s1  <= dst_q + k_q;
		if (state_q == ST_FINISH && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {7'd0, total_q, free_sp, res_lout_q, res_dout_q, res_sout_q,
				res_status_q};
		end
		if (accept) begin
			cmd_q        <= in_cmd;
			slot_q       <= in_slot;
			bidx_q       <= in_bidx;
			len_q        <= in_len;
			data_q       <= in_data;
			last_q       <= s_tlast;
			res_status_q <= STS_OK;
			res_sout_q   <= '0;
			res_dout_q   <= '0;
			res_lout_q   <= '0;
		end
		if ((fly || state_q == ST_STREAM) && b_last) begin
			if (failed_q) begin
				res_status_q <= pend_q[2:0];
			end else if (b_cmd == CMD_OVERWRITE) begin
				z_q <= tail_from;
			end else begin
				res_sout_q <= pend_q;
			end
		end
		case (state_q)
			ST_DISP: begin
				idx_q     <= '0;
				found_q   <= 1'b0;
				reclaim_q <= '0;
				z_q       <= '0;
				if (cmd_q == CMD_FORMAT && special_size_q > 12'(MAX_SPECIAL)) begin
					res_status_q <= STS_TOO_LONG;
				end
				if ((cmd_q == CMD_READ || cmd_q == CMD_DELETE) && slot_bad) begin
					res_status_q <= STS_NO_SLOT;
				end
			end
			ST_SCAN_EV: begin
				if (slot_rdata.st != SL_OCCUPIED && !found_q) begin
					found_q    <= 1'b1;
					free_idx_q <= idx_q[SLOT_AW-1:0];
				end
				if (slot_rdata.st == SL_DELETED) begin
					reclaim_q <= reclaim_q + {1'b0, slot_rdata.len};
				end
				idx_q <= idx_q + CNT_W'(1);
			end
			ST_FIT: begin
				idx_q <= '0;
				n_q   <= '0;
				z_q   <= lower_q;
			end
			ST_C1_EV: begin
				cp_off_q <= slot_rdata.off;
				cp_len_q <= slot_rdata.len;
				k_q      <= '0;
				idx_q    <= idx_q + CNT_W'(1);
			end
			ST_C1_CP, ST_C3_CP: begin
				n_q <= n_q + PTR_W'(1);
				k_q <= k_q + PTR_W'(1);
			end
			ST_C2: begin
				if (z_q < special_q) begin
					z_q <= z_q + PTR_W'(1);
				end else begin
					top_q <= special_q;
					n_q   <= '0;
					idx_q <= '0;
				end
			end
			ST_C3_EV: begin
				if (slot_rdata.st == SL_OCCUPIED) top_q <= c3_top;
				cp_len_q <= slot_rdata.len;
				dst_q    <= c3_top;
				k_q      <= '0;
				idx_q    <= idx_q + CNT_W'(1);
			end
			ST_ALLOC: begin
				cur_off_q <= alloc_up;
				cur_len_q <= {1'b0, len_q};
			end
			ST_OW_EV: begin
				cur_off_q <= slot_rdata.off;
				cur_len_q <= slot_rdata.len;
			end
			ST_ZTAIL, ST_FMT: z_q <= z_q + PTR_W'(1);
			ST_ACC_EV: begin
				rd_oob_q <= rd_addr[PTR_W-1];
				if (slot_rdata.st != SL_OCCUPIED) begin
					res_status_q <= STS_NOT_OCC;
				end else if (cmd_q == CMD_READ) begin
					res_lout_q <= slot_rdata.len[LEN_W-1:0];
					if ({1'b0, bidx_q} >= slot_rdata.len) res_status_q <= STS_RANGE;
				end
			end
			ST_RD_WAIT: res_dout_q <= rd_oob_q ? 8'h00 : page_rdata;
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

[rtl/slotted_page_record_store.sv]
// Top level of the slotted page record store: sequencer plus page, scratch
// and slot-table RAMs. Depends on sprs_pkg, sprs_ram and sprs_ctrl.
//
//  channel | signals                     | content
//  --------+-----------------------------+-------------------------------------------
//  in      | s_tvalid/s_tready/s_tdata   | command, slot_number, byte_index,
//          | s_tlast                     | record_length, data_byte; tlast = last
//  out     | m_tvalid/m_tready/m_tdata   | status, slot_number_out, data_byte_out,
//          |                             | record_length_out, contiguous_free, slots_in_use
//  cfg     | cfg_we/cfg_wdata            | special_size
//
// A continuing record byte is taken while the block stays idle. The first byte of
// an insert walks the slot table, reading and then evaluating each slot, and
// compaction copies every live byte to scratch, zeroes the gap and copies the bytes
// back. An accepted format sweeps the whole page byte by byte; read and delete look
// up their slot, a read then fetches its byte, and overwrite zeroes a record's tail.
// Page bytes all move through the single page RAM port. Reset takes effect at once;
// the page holds no defined data until a format. A stalled output holds only items that report.
`default_nettype none

module slotted_page_record_store import sprs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // command, slot_number, byte_index, record_length, data_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // status, slot_number_out, data_byte_out,
	                                    // record_length_out, contiguous_free, slots_in_use
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_wdata
);

	byte_req_t   page_req, scr_req;
	slot_req_t   slot_req;
	logic [7:0]  page_rdata, scr_rdata;
	slot_entry_t slot_rdata;

	sprs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.page_req   (page_req),
		.page_rdata (page_rdata),
		.scr_req    (scr_req),
		.scr_rdata  (scr_rdata),
		.slot_req   (slot_req),
		.slot_rdata (slot_rdata)
	);

	sprs_ram #(.W(8), .AW(PAGE_AW)) u_page (
		.clk   (clk),
		.we    (page_req.we),
		.addr  (page_req.addr),
		.wdata (page_req.wdata),
		.rdata (page_rdata)
	);

	sprs_ram #(.W(8), .AW(PAGE_AW)) u_scratch (
		.clk   (clk),
		.we    (scr_req.we),
		.addr  (scr_req.addr),
		.wdata (scr_req.wdata),
		.rdata (scr_rdata)
	);

	sprs_ram #(.W($bits(slot_entry_t)), .AW(SLOT_AW)) u_slots (
		.clk   (clk),
		.we    (slot_req.we),
		.addr  (slot_req.addr),
		.wdata (slot_req.wdata),
		.rdata (slot_rdata)
	);

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for slotted_page_record_store: drives command streams, predicts
// every response in a scoreboard class, and checks the responses field by field.
// Depends on sprs_pkg and the slotted_page_record_store RTL.
`default_nettype none

module tb_top;
	import sprs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
	localparam int CFG_INDEX = 0;

	typedef struct {
		logic [2:0]       status;
		logic [9:0]       slot;
		logic [7:0]       dbyte;
		logic [11:0]      rlen;
		logic [PTR_W-1:0] free;
		logic [CNT_W-1:0] used;
	} resp_t;

	class page_scoreboard;
		logic [7:0]       page_mem [PAGE_BYTES];
		logic [7:0]       scratch [PAGE_BYTES];
		int               soff [MAX_SLOTS];
		int               slen [MAX_SLOTS];
		logic [1:0]       sst [MAX_SLOTS];
		int               lower, upper, special_start, slot_total;
		int               bcnt, pend, special_size;
		bit               failed;
		resp_t            expected_q[$];
		int               errors;

		function void reset_state();
			special_size = 0;
			format_page(0);
			bcnt = 0;
			pend = 0;
			failed = 0;
		endfunction

		function void format_page(int sp);
			for (int i = 0; i < PAGE_BYTES; i++) page_mem[i] = 8'h00;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				soff[i] = 0;
				slen[i] = 0;
				sst[i] = SL_EMPTY;
			end
			lower = HEADER_BYTES;
			special_start = PAGE_BYTES - sp;
			upper = special_start;
			slot_total = 0;
		endfunction

		function int free_span();
			return upper >= lower ? upper - lower : 0;
		endfunction

		function void wr(int a, logic [7:0] v);
			if (a < PAGE_BYTES) page_mem[a] = v;
		endfunction

		function void compact();
			int n, top;
			n = 0;
			for (int i = 0; i < slot_total; i++) begin
				if (sst[i] == SL_OCCUPIED) begin
					for (int k = 0; k < slen[i]; k++) begin
						if (n < PAGE_BYTES)
							scratch[n] = (soff[i] + k < PAGE_BYTES) ? page_mem[soff[i] + k] : 8'h00;
						n++;
					end
				end else begin
					soff[i] = 0;
					slen[i] = 0;
				end
			end
			for (int k = lower; k < special_start; k++) wr(k, 8'h00);
			top = special_start;
			n = 0;
			for (int i = 0; i < slot_total; i++) begin
				if (sst[i] != SL_OCCUPIED) continue;
				top = top >= slen[i] ? top - slen[i] : 0;
				for (int k = 0; k < slen[i]; k++) begin
					wr(top + k, n < PAGE_BYTES ? scratch[n] : 8'h00);
					n++;
				end
				soff[i] = top;
			end
			upper = top;
		endfunction

		function logic [2:0] open_insert(int len);
			int idx, req, reclaim;
			bit found;
			idx = 0;
			found = 0;
			reclaim = 0;
			if (len == 0) return STS_ZERO_LEN;
			for (int i = 0; i < slot_total; i++)
				if (sst[i] == SL_EMPTY || sst[i] == SL_DELETED) begin
					idx = i;
					found = 1;
					break;
				end
			if (!found && slot_total >= MAX_SLOTS) return STS_NO_SLOT;
			req = len + (found ? 0 : SLOT_BYTES);
			if (free_span() < req) begin
				for (int i = 0; i < slot_total; i++)
					if (sst[i] == SL_DELETED) reclaim += slen[i];
				if (free_span() + reclaim < req) return STS_NO_SPACE;
				compact();
				if (free_span() < req) return STS_NO_SPACE;
			end
			if (!found) begin
				idx = slot_total;
				slot_total++;
				lower += SLOT_BYTES;
			end
			upper -= len;
			soff[idx] = upper;
			slen[idx] = len;
			sst[idx] = SL_OCCUPIED;
			pend = idx;
			return STS_OK;
		endfunction

		function logic [2:0] open_overwrite(int slot, int len);
			if (slot >= slot_total) return STS_NO_SLOT;
			if (sst[slot] != SL_OCCUPIED) return STS_NOT_OCC;
			if (len > slen[slot]) return STS_TOO_LONG;
			pend = slot;
			return STS_OK;
		endfunction

		// Note one accepted input transaction and queue its response, if any.
		function void note(logic [2:0] cmd, int slot, int bidx, int len, logic [7:0] data,
				bit last);
			resp_t r;
			logic [2:0] code;
			bit have;
			r.status = STS_OK;
			r.slot = '0;
			r.dbyte = '0;
			r.rlen = '0;
			if (cmd > CMD_DELETE) return;
			if (cmd == CMD_INSERT || cmd == CMD_OVERWRITE) begin
				if (bcnt == 0) begin
					code = (cmd == CMD_INSERT) ? open_insert(len) : open_overwrite(slot, len);
					failed = code != STS_OK;
					if (failed) pend = code;
				end
				have = !failed && pend < MAX_SLOTS;
				if (have && bcnt < slen[pend] && bcnt < len) wr(soff[pend] + bcnt, data);
				if (!last) begin
					if (bcnt < 8191) bcnt++;
					return;
				end
				if (failed) r.status = pend[2:0];
				else if (have) begin
					if (cmd == CMD_OVERWRITE) begin
						for (int a = (len < slen[pend] ? len : slen[pend]); a < slen[pend]; a++)
							wr(soff[pend] + a, 8'h00);
					end else
						r.slot = pend;
				end
				bcnt = 0;
				failed = 0;
			end else begin
				bcnt = 0;
				failed = 0;
				if (cmd == CMD_FORMAT) begin
					if (special_size > MAX_SPECIAL) r.status = STS_TOO_LONG;
					else format_page(special_size);
				end else if (slot >= slot_total) r.status = STS_NO_SLOT;
				else if (sst[slot] != SL_OCCUPIED) r.status = STS_NOT_OCC;
				else if (cmd == CMD_READ) begin
					r.rlen = slen[slot];
					if (bidx >= slen[slot]) r.status = STS_RANGE;
					else r.dbyte = (soff[slot] + bidx < PAGE_BYTES) ?
						page_mem[soff[slot] + bidx] : 8'h00;
				end else
					sst[slot] = SL_DELETED;
			end
			r.free = free_span();
			r.used = slot_total;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		task check(logic [63:0] d);
			resp_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected response %h", d));
				return;
			end
			e = expected_q.pop_front();
			if (d[2:0] !== e.status) report($sformatf("status %0d exp %0d", d[2:0], e.status));
			if (d[12:3] !== e.slot) report($sformatf("slot %0d exp %0d", d[12:3], e.slot));
			if (d[20:13] !== e.dbyte) report($sformatf("data %h exp %h", d[20:13], e.dbyte));
			if (d[32:21] !== e.rlen) report($sformatf("length %0d exp %0d", d[32:21], e.rlen));
			if (d[45:33] !== e.free) report($sformatf("free %0d exp %0d", d[45:33], e.free));
			if (d[56:46] !== e.used) report($sformatf("slots %0d exp %0d", d[56:46], e.used));
		endtask
	endclass

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tlast;
	logic [47:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [63:0] m_tdata;
	logic        cfg_we;
	logic [11:0] cfg_wdata;

	page_scoreboard sb;
	int  sent;
	bit  quiet;

	slotted_page_record_store DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("slotted_page_record_store test failed");
		$finish;
	end

	// Result side backpressure.
	initial begin
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready = 0;
				repeat ($urandom_range(1, 7) - 1) @(negedge clk);
			end else begin
				m_tready = 1;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check(m_tdata);

	task automatic send(logic [2:0] cmd, int slot, int bidx, int len, logic [7:0] data,
			bit last);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			s_tvalid = 0;
			repeat ($urandom_range(1, 7) - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1;
		s_tlast = last;
		s_tdata = {3'b000, data, len[11:0], bidx[11:0], slot[9:0], cmd};
		do @(posedge clk); while (!s_tready);
		sb.note(cmd, slot[9:0], bidx[11:0], len[11:0], data, last);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_special(int v);
		drain();
		@(negedge clk);
		cfg_we = 1;
		cfg_wdata = v;
		@(posedge clk);
		if (CFG_INDEX == 0) sb.special_size = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	// Streams a record; when mix is set the final byte uses the other write opcode.
	task automatic stream(logic [2:0] cmd, int slot, int len, int nbytes, bit mix);
		logic [2:0] c;
		for (int i = 0; i < nbytes; i++) begin
			c = cmd;
			if (mix && i == nbytes - 1) c = (cmd == CMD_INSERT) ? CMD_OVERWRITE : CMD_INSERT;
			send(c, slot, $urandom_range(0, 4095), len, $urandom, i == nbytes - 1);
		end
	endtask

	function automatic int pick_slot();
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
		return $urandom_range(0, sb.slot_total);
	endfunction

	task automatic random_op();
		int sel, slot, len, n, bidx;
		sel = $urandom_range(0, 99);
		slot = pick_slot();
		if (sel < 40) begin
			len = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 40);
			if ($urandom_range(0, 19) == 0) len = $urandom_range(100, 600);
			if ($urandom_range(0, 49) == 0) len = 4095;
			n = len > 50 && len != 600 ? 3 : (len == 0 ? 1 : len);
			if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n + 2);
			stream(CMD_INSERT, slot, len, n, $urandom_range(0, 15) == 0);
		end else if (sel < 65) begin
			bidx = (slot < sb.slot_total && $urandom_range(0, 5) != 0) ?
				$urandom_range(0, sb.slen[slot]) : $urandom_range(0, 4095);
			send(CMD_READ, slot, bidx, $urandom, $urandom, $urandom);
		end else if (sel < 77) begin
			len = slot < sb.slot_total ? $urandom_range(0, sb.slen[slot] + 1) : 4;
			n = len == 0 ? 1 : len;
			if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n + 2);
			stream(CMD_OVERWRITE, slot, len, n, $urandom_range(0, 15) == 0);
		end else if (sel < 92) begin
			send(CMD_DELETE, slot, $urandom, $urandom, $urandom, $urandom);
		end else if (sel < 94) begin
			send(CMD_FORMAT, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else if (sel < 97) begin
			send($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI), $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end else begin
			// short stream: the insert ends after three of its eight bytes, then a read follows
			stream(CMD_INSERT, slot, 8, 3, 0);
			send(CMD_READ, pick_slot(), $urandom_range(0, 8), $urandom, $urandom, 1);
		end
	endtask

	initial begin
		int sizes [6] = '{3600, 0, 3900, 4095, 3300, 4072};
		sb = new();
		sb.reset_state();
		quiet = 0;
		sent = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tlast = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed
		write_special(0);
		send(CMD_FORMAT, 0, 0, 0, 0, 0);
		stream(CMD_INSERT, 0, 0, 1, 0);
		send(CMD_INSERT, 1023, 4095, 3, 8'hFF, 0);
		send(CMD_INSERT, 0, 0, 3, 8'h00, 0);
		send(CMD_INSERT, 0, 0, 3, 8'hA5, 1);
		send(CMD_READ, 0, 0, 0, 0, 0);
		send(CMD_READ, 0, 2, 0, 0, 1);
		send(CMD_READ, 0, 3, 0, 0, 0);
		send(CMD_READ, 0, 4095, 4095, 8'hFF, 1);
		send(CMD_READ, 1023, 0, 0, 0, 0);
		send(CMD_OVERWRITE, 0, 0, 1, 8'h5A, 1);
		send(CMD_READ, 0, 1, 0, 0, 0);
		send(CMD_OVERWRITE, 0, 0, 5, 8'h11, 1);
		send(CMD_DELETE, 0, 0, 0, 0, 0);
		send(CMD_READ, 0, 0, 0, 0, 0);
		send(CMD_DELETE, 0, 0, 0, 0, 0);
		stream(CMD_INSERT, 0, 2, 2, 0);
		send(CMD_UNUSED_HI, 1023, 4095, 4095, 8'hFF, 1);
		write_special(4095);
		send(CMD_FORMAT, 0, 0, 0, 0, 0);
		write_special(MAX_SPECIAL);
		send(CMD_FORMAT, 0, 0, 0, 0, 0);
		stream(CMD_INSERT, 0, 1, 1, 0);

		// random phases, each starting from a drained page and a format command
		for (int p = 0; sent < 1600; p++) begin
			write_special(p < 6 ? sizes[p] : $urandom_range(3000, 4000));
			send(CMD_FORMAT, $urandom, $urandom, $urandom, $urandom, $urandom);
			for (int k = 0; k < 60 && sent < 1600; k++) begin
				if (sent > 1400) quiet = 1;
				random_op();
			end
		end
		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("slotted_page_record_store test passed");
		else
			$display("slotted_page_record_store test failed");
		$finish;
	end
endmodule

`default_nettype wire

[filelist.f]
rtl/sprs_pkg.sv
rtl/sprs_ram.sv
rtl/sprs_ctrl.sv
rtl/slotted_page_record_store.sv
dv/tb_top.sv
